// ===== rtl/core/stuffed_frame_receiver_crc8_core_defines.svh =====
// assertion macros for the stuffed frame receiver core
`ifndef STUFFED_FRAME_RECEIVER_CRC8_CORE_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_CRC8_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfr assertion failed");

`endif

// ===== rtl/core/sfr_pkg.sv =====
// types, constants and crc function shared by the stuffed frame receiver
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam logic [7:0]  CrcPoly  = 8'h18;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ADDR = 3'd1,
    PH_CMD  = 3'd2,
    PH_NBT  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_OWN_ADDR    = 3'd0,
    REG_FRAME_END   = 3'd1,
    REG_ESCAPE      = 3'd2,
    REG_ESC_END     = 3'd3,
    REG_ESC_ESCAPE  = 3'd4,
    REG_CRC_START   = 3'd5,
    REG_MAX_LENGTH  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [6:0] own_address;
    logic [7:0] frame_end_code;
    logic [7:0] escape_code;
    logic [7:0] escaped_end_code;
    logic [7:0] escaped_escape_code;
    logic [7:0] crc_start;
    logic [7:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] value;
    logic [7:0] position;
  } res_t;

  // reflected crc-8, one byte, lsb first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] data;
    crc  = crc_in;
    data = data_in;
    for (int k = 0; k < 8; k++) begin
      if (data[0] ^ crc[0]) begin
        crc = ((crc ^ CrcPoly) >> 1) | 8'h80;
      end else begin
        crc = (crc >> 1) & 8'h7F;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

endpackage

// ===== rtl/core/sfr_rx_if.sv =====
// handshake channel carrying received line words
`timescale 1ns / 1ps
interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_error;

  modport source (output valid, output rx_byte, output line_error, input ready);
  modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

// ===== rtl/core/sfr_res_if.sv =====
// handshake channel carrying result words
`timescale 1ns / 1ps
interface sfr_res_if;
  logic          valid;
  logic          ready;
  sfr_pkg::kind_e kind;
  logic [7:0]    value;
  logic [7:0]    position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

// ===== rtl/core/stuffed_frame_receiver_crc8_core.sv =====
// top level of the stuffed frame receiver with crc-8 check
//
//   channel  dir  handshake      payload
//   rx_i     in   valid/ready    rx_byte, line_error
//   res_o    out  valid/ready    kind, value, position
//   apb      in   psel/penable   paddr, pwdata -> prdata, pready
//
// one word per cycle sustained unless res_o stalls; a word sees an input
// register, then the unstuffing and crc logic, then the result register
// reset clears the packet state and loads the default codes; no clearing pass
// a stalled result register holds the input register, which, once full, holds rx_i
`timescale 1ns / 1ps
module stuffed_frame_receiver_crc8_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sfr_rx_if.sink                        rx_i,
  sfr_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfr_pkg::ApbAddrW-1:0]  paddr,
  input  logic [sfr_pkg::ApbDataW-1:0]  pwdata,
  output logic [sfr_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::res_t res;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_err_q;
  logic       out_valid_q;
  sfr_pkg::kind_e out_kind_q;
  logic [7:0] out_value_q;
  logic [7:0] out_pos_q;
  logic       adv;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  sfr_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_idx_i  (paddr[4:2]),
    .wr_data_i (pwdata[7:0]),
    .rd_idx_i  (paddr[4:2]),
    .rd_data_o (prdata),
    .cfg_o     (cfg)
  );

  assign adv        = !out_valid_q || res_o.ready;
  assign rx_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
      in_err_q  <= rx_i.line_error;
    end
  end

  sfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_valid_q && adv),
    .rx_byte_i    (in_byte_q),
    .line_error_i (in_err_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_kind_q  <= res.kind;
      out_value_q <= res.value;
      out_pos_q   <= res.position;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.kind     = out_kind_q;
  assign res_o.value    = out_value_q;
  assign res_o.position = out_pos_q;

endmodule

// ===== rtl/core/sfr_cfg_regs.sv =====
// apb configuration registers of the stuffed frame receiver
`timescale 1ns / 1ps
module sfr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [2:0]                    wr_idx_i,
  input  logic [7:0]                    wr_data_i,
  input  logic [2:0]                    rd_idx_i,
  output logic [sfr_pkg::ApbDataW-1:0]  rd_data_o,
  output sfr_pkg::cfg_t                 cfg_o
);

  sfr_pkg::cfg_t cfg_q;
  sfr_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (sfr_pkg::reg_idx_e'(wr_idx_i))
        sfr_pkg::REG_OWN_ADDR:   cfg_d.own_address         = wr_data_i[6:0];
        sfr_pkg::REG_FRAME_END:  cfg_d.frame_end_code      = wr_data_i;
        sfr_pkg::REG_ESCAPE:     cfg_d.escape_code         = wr_data_i;
        sfr_pkg::REG_ESC_END:    cfg_d.escaped_end_code    = wr_data_i;
        sfr_pkg::REG_ESC_ESCAPE: cfg_d.escaped_escape_code = wr_data_i;
        sfr_pkg::REG_CRC_START:  cfg_d.crc_start           = wr_data_i;
        sfr_pkg::REG_MAX_LENGTH: cfg_d.max_length          = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address         <= 7'd1;
      cfg_q.frame_end_code      <= 8'd192;
      cfg_q.escape_code         <= 8'd219;
      cfg_q.escaped_end_code    <= 8'd220;
      cfg_q.escaped_escape_code <= 8'd221;
      cfg_q.crc_start           <= 8'd222;
      cfg_q.max_length          <= 8'd128;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    rd_data_o = '0;
    unique case (sfr_pkg::reg_idx_e'(rd_idx_i))
      sfr_pkg::REG_OWN_ADDR:   rd_data_o[6:0] = cfg_q.own_address;
      sfr_pkg::REG_FRAME_END:  rd_data_o[7:0] = cfg_q.frame_end_code;
      sfr_pkg::REG_ESCAPE:     rd_data_o[7:0] = cfg_q.escape_code;
      sfr_pkg::REG_ESC_END:    rd_data_o[7:0] = cfg_q.escaped_end_code;
      sfr_pkg::REG_ESC_ESCAPE: rd_data_o[7:0] = cfg_q.escaped_escape_code;
      sfr_pkg::REG_CRC_START:  rd_data_o[7:0] = cfg_q.crc_start;
      sfr_pkg::REG_MAX_LENGTH: rd_data_o[7:0] = cfg_q.max_length;
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/sfr_parser.sv =====
// unstuffing, packet state tracking and crc check for one word per cycle while fire_i is high
`timescale 1ns / 1ps
`include "stuffed_frame_receiver_crc8_core_defines.svh"
module sfr_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          line_error_i,
  input  sfr_pkg::cfg_t cfg_i,
  output sfr_pkg::res_t res_o
);

  sfr_pkg::phase_e phase_q, phase_d;
  logic [7:0] prev_q, prev_d;
  logic [7:0] crc_q, crc_d;
  logic [6:0] cmd_q, cmd_d;
  logic [7:0] count_q, count_d;
  logic [7:0] index_q, index_d;

  logic            is_start;
  logic            esc_pending;
  logic            bad_esc;
  logic            skip;
  logic [7:0]      dec;
  logic            is_addr;
  logic            addr_ok;
  logic            more;
  logic            live;
  logic            in_frame;
  logic [7:0]      crc_next;
  sfr_pkg::phase_e eff_phase;

  // shared decode of the current word
  always_comb begin
    is_start    = rx_byte_i == cfg_i.frame_end_code;
    esc_pending = prev_q == cfg_i.escape_code;
    bad_esc     = esc_pending && (rx_byte_i != cfg_i.escaped_escape_code)
                  && (rx_byte_i != cfg_i.escaped_end_code);
    skip        = !esc_pending && (rx_byte_i == cfg_i.escape_code);
    if (!esc_pending) begin
      dec = rx_byte_i;
    end else if (rx_byte_i == cfg_i.escaped_escape_code) begin
      dec = cfg_i.escape_code;
    end else begin
      dec = cfg_i.frame_end_code;
    end
    is_addr   = (phase_q == sfr_pkg::PH_ADDR) && dec[7];
    addr_ok   = (dec[6:0] == 7'd0) || (dec[6:0] == cfg_i.own_address);
    more      = index_q < count_q;
    in_frame  = fire_i && !line_error_i && !is_start && (phase_q != sfr_pkg::PH_IDLE);
    live      = in_frame && !bad_esc && !skip;
    eff_phase = (phase_q == sfr_pkg::PH_ADDR) ? sfr_pkg::PH_CMD : phase_q;
    crc_next  = sfr_pkg::crc_feed(crc_q, is_addr ? {1'b0, dec[6:0]} : dec);
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    prev_d  = prev_q;
    crc_d   = crc_q;
    cmd_d   = cmd_q;
    count_d = count_q;
    index_d = index_q;
    if (fire_i && line_error_i) begin
      phase_d = sfr_pkg::PH_IDLE;
    end else if (fire_i && is_start) begin
      prev_d  = rx_byte_i;
      crc_d   = sfr_pkg::crc_feed(cfg_i.crc_start, rx_byte_i);
      phase_d = sfr_pkg::PH_ADDR;
    end else if (in_frame) begin
      prev_d = rx_byte_i;
      if (bad_esc) begin
        phase_d = sfr_pkg::PH_IDLE;
      end else if (!skip) begin
        if (is_addr) begin
          if (addr_ok) begin
            crc_d   = crc_next;
            phase_d = sfr_pkg::PH_CMD;
          end else begin
            phase_d = sfr_pkg::PH_IDLE;
          end
        end else begin
          unique case (eff_phase)
            sfr_pkg::PH_CMD: begin
              if (dec[7]) begin
                phase_d = sfr_pkg::PH_IDLE;
              end else begin
                cmd_d   = dec[6:0];
                crc_d   = crc_next;
                phase_d = sfr_pkg::PH_NBT;
              end
            end
            sfr_pkg::PH_NBT: begin
              if (dec > cfg_i.max_length) begin
                phase_d = sfr_pkg::PH_IDLE;
              end else begin
                count_d = dec;
                index_d = 8'd0;
                crc_d   = crc_next;
                phase_d = sfr_pkg::PH_DATA;
              end
            end
            sfr_pkg::PH_DATA: begin
              if (more) begin
                index_d = index_q + 8'd1;
                crc_d   = crc_next;
              end else begin
                phase_d = sfr_pkg::PH_IDLE;
              end
            end
            default: phase_d = sfr_pkg::PH_IDLE;
          endcase
        end
      end
    end
  end

  // result word
  always_comb begin
    res_o.valid    = 1'b0;
    res_o.kind     = sfr_pkg::KIND_ERR;
    res_o.value    = 8'd0;
    res_o.position = 8'd0;
    if (fire_i && line_error_i) begin
      res_o.valid = 1'b1;
    end else if (in_frame && bad_esc) begin
      res_o.valid = 1'b1;
    end else if (live && !is_addr) begin
      unique case (eff_phase)
        sfr_pkg::PH_CMD: res_o.valid = dec[7];
        sfr_pkg::PH_NBT: res_o.valid = dec > cfg_i.max_length;
        sfr_pkg::PH_DATA: begin
          res_o.valid = 1'b1;
          if (more) begin
            res_o.kind     = sfr_pkg::KIND_BYTE;
            res_o.value    = dec;
            res_o.position = index_q;
          end else if (dec == crc_q) begin
            res_o.kind     = sfr_pkg::KIND_GOOD;
            res_o.value    = {1'b0, cmd_q};
            res_o.position = count_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfr_pkg::PH_IDLE;
      prev_q  <= 8'd0;
      crc_q   <= 8'd0;
      cmd_q   <= 7'd0;
      count_q <= 8'd0;
      index_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      crc_q   <= crc_d;
      cmd_q   <= cmd_d;
      count_q <= count_d;
      index_q <= index_d;
    end
  end

  `SFR_ASSERT_NOW(a_res_needs_word, res_o.valid, fire_i)
  `SFR_ASSERT_NEXT(a_line_err_idle, fire_i && line_error_i, phase_q == sfr_pkg::PH_IDLE)
  `SFR_ASSERT_NOW(a_index_bound, phase_q == sfr_pkg::PH_DATA, index_q <= count_q)
  `SFR_ASSERT_NOW(a_good_full, res_o.valid && (res_o.kind == sfr_pkg::KIND_GOOD),
                  (index_q == count_q) && (res_o.position == count_q))

endmodule
